// ===== rtl/core/asbe_pkg.sv =====
// shared types and constants for the array list stack bag engine
package asbe_pkg;

  typedef enum logic [3:0] {
    OP_PUSH         = 4'd0,
    OP_READ         = 4'd1,
    OP_WRITE        = 4'd2,
    OP_SWAP         = 4'd3,
    OP_REMOVE_AT    = 4'd4,
    OP_TOP          = 4'd5,
    OP_POP          = 4'd6,
    OP_CONTAINS     = 4'd7,
    OP_REMOVE_VALUE = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_SWAP_B,
    S_SWAP_W,
    S_SWAP_W2,
    S_SHIFT,
    S_SCAN,
    S_DONE
  } state_t;

  // packed so that read_value sits in the lowest bits
  typedef struct packed {
    status_t     status;
    logic        empty_res;
    logic [8:0]  count;
    logic        found;
    logic [31:0] read_value;
  } res_t;

  localparam int IN_BITS  = 56;
  localparam int OUT_BITS = 48;

endpackage

// ===== rtl/core/asbe_mem.sv =====
// element store: one write port, one registered read port
module asbe_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic signed [WIDTH-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic signed [WIDTH-1:0]          rdata
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/asbe_ctrl.sv =====
// sequencer: decodes one item, walks the element store and builds the result
module asbe_ctrl #(
  parameter int SLOTS     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0]                        opcode,
  input  logic [7:0]                        index_a,
  input  logic [7:0]                        index_b,
  input  logic signed [31:0]                value,
  output logic                              res_valid,
  input  logic                              res_ready,
  output asbe_pkg::res_t                    res,
  output logic                              mem_we,
  output logic [$clog2(SLOTS)-1:0]          mem_waddr,
  output logic signed [WORD_BITS-1:0]       mem_wdata,
  output logic [$clog2(SLOTS)-1:0]          mem_raddr,
  input  logic signed [WORD_BITS-1:0]       mem_rdata
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  asbe_pkg::state_t  state, state_next;
  asbe_pkg::status_t status, start_status;
  logic [3:0]                op;
  logic [7:0]                ia, ib;
  logic signed [WORD_BITS-1:0] val, tmp;
  logic [CW-1:0]             count, rp;
  logic [AW-1:0]             wp;
  logic                      pend, found;
  logic [31:0]               rd;

  logic                      more, hit, ia_ok, ib_ok, cnt_full, cnt_zero;
  logic [AW-1:0]             ia_addr, ib_addr, top_addr;
  asbe_pkg::state_t          start_state;

  assign more     = rp < count;
  assign hit      = pend && (mem_rdata == val);
  assign ia_ok    = XW'(index_a) < XW'(count);
  assign ib_ok    = XW'(index_b) < XW'(count);
  assign cnt_full = count == CW'(SLOTS);
  assign cnt_zero = count == '0;
  assign ia_addr  = AW'(ia);
  assign ib_addr  = AW'(ib);
  assign top_addr = AW'(count - 1'b1);

  // status and first state of a newly accepted item
  always_comb begin
    start_status = asbe_pkg::ST_OK;
    start_state  = asbe_pkg::S_DONE;
    if (opcode == asbe_pkg::OP_PUSH) begin
      if (cnt_full) start_status = asbe_pkg::ST_FULL;
      else          start_state  = asbe_pkg::S_EXEC;
    end else if (opcode <= asbe_pkg::OP_REMOVE_VALUE) begin
      if (cnt_zero) begin
        start_status = asbe_pkg::ST_EMPTY;
      end else begin
        case (opcode)
          asbe_pkg::OP_READ, asbe_pkg::OP_WRITE: begin
            if (ia_ok) start_state  = asbe_pkg::S_EXEC;
            else       start_status = asbe_pkg::ST_RANGE;
          end
          asbe_pkg::OP_SWAP: begin
            if (ia_ok && ib_ok) start_state  = asbe_pkg::S_EXEC;
            else                start_status = asbe_pkg::ST_RANGE;
          end
          asbe_pkg::OP_REMOVE_AT: begin
            if (ia_ok) start_state  = asbe_pkg::S_SHIFT;
            else       start_status = asbe_pkg::ST_RANGE;
          end
          asbe_pkg::OP_CONTAINS, asbe_pkg::OP_REMOVE_VALUE: begin
            start_state = asbe_pkg::S_SCAN;
          end
          default: begin
            start_state = asbe_pkg::S_EXEC;
          end
        endcase
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      asbe_pkg::S_IDLE: begin
        if (in_valid) state_next = start_state;
      end
      asbe_pkg::S_EXEC: begin
        if (op == asbe_pkg::OP_SWAP) begin
          state_next = asbe_pkg::S_SWAP_B;
        end else if (op == asbe_pkg::OP_READ || op == asbe_pkg::OP_TOP) begin
          state_next = asbe_pkg::S_WAIT;
        end else begin
          state_next = asbe_pkg::S_DONE;
        end
      end
      asbe_pkg::S_WAIT:    state_next = asbe_pkg::S_DONE;
      asbe_pkg::S_SWAP_B:  state_next = asbe_pkg::S_SWAP_W;
      asbe_pkg::S_SWAP_W:  state_next = asbe_pkg::S_SWAP_W2;
      asbe_pkg::S_SWAP_W2: state_next = asbe_pkg::S_DONE;
      asbe_pkg::S_SHIFT: begin
        if (!more && !pend) state_next = asbe_pkg::S_DONE;
      end
      asbe_pkg::S_SCAN: begin
        if (hit) begin
          state_next = (op == asbe_pkg::OP_CONTAINS) ? asbe_pkg::S_DONE : asbe_pkg::S_SHIFT;
        end else if (!more && !pend) begin
          state_next = asbe_pkg::S_DONE;
        end
      end
      asbe_pkg::S_DONE: begin
        if (res_ready) state_next = asbe_pkg::S_IDLE;
      end
      default: state_next = asbe_pkg::S_IDLE;
    endcase
  end

  // outputs and memory port
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wp;
    mem_wdata = mem_rdata;
    mem_raddr = rp[AW-1:0];
    unique case (state)
      asbe_pkg::S_IDLE: in_ready = 1'b1;
      asbe_pkg::S_EXEC: begin
        case (op)
          asbe_pkg::OP_PUSH: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(count);
            mem_wdata = val;
          end
          asbe_pkg::OP_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = ia_addr;
            mem_wdata = val;
          end
          asbe_pkg::OP_POP: begin
            mem_we    = 1'b1;
            mem_waddr = top_addr;
            mem_wdata = '0;
          end
          asbe_pkg::OP_TOP: mem_raddr = top_addr;
          default:          mem_raddr = ia_addr;
        endcase
      end
      asbe_pkg::S_WAIT: ;
      asbe_pkg::S_SWAP_B: mem_raddr = ib_addr;
      asbe_pkg::S_SWAP_W: begin
        mem_we    = 1'b1;
        mem_waddr = ia_addr;
      end
      asbe_pkg::S_SWAP_W2: begin
        mem_we    = 1'b1;
        mem_waddr = ib_addr;
        mem_wdata = tmp;
      end
      asbe_pkg::S_SHIFT: mem_we = pend;
      asbe_pkg::S_SCAN: ;
      asbe_pkg::S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asbe_pkg::S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        asbe_pkg::S_IDLE: begin
          if (in_valid) begin
            op     <= opcode;
            ia     <= index_a;
            ib     <= index_b;
            val    <= WORD_BITS'(value);
            status <= start_status;
            found  <= 1'b0;
            rd     <= '0;
            wp     <= AW'(index_a);
            rp     <= (opcode == asbe_pkg::OP_REMOVE_AT) ? CW'(index_a) + 1'b1 : '0;
            pend   <= 1'b0;
          end
        end
        asbe_pkg::S_EXEC: begin
          if (op == asbe_pkg::OP_PUSH)     count <= count + 1'b1;
          else if (op == asbe_pkg::OP_POP) count <= count - 1'b1;
        end
        asbe_pkg::S_WAIT:   rd  <= 32'(mem_rdata);
        asbe_pkg::S_SWAP_B: tmp <= mem_rdata;
        asbe_pkg::S_SHIFT: begin
          if (pend) wp <= wp + 1'b1;
          if (more) begin
            rp   <= rp + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) count <= count - 1'b1;
          end
        end
        asbe_pkg::S_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            pend  <= 1'b0;
            wp    <= AW'(rp - 1'b1);
          end else if (more) begin
            rp   <= rp + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.status     = status;
  assign res.empty_res  = cnt_zero;
  assign res.count      = 9'(count);
  assign res.found      = found;
  assign res.read_value = rd;

endmodule

// ===== rtl/core/array_stack_bag_engine_core.sv =====
// top level of the array list stack bag engine
//
// one item in on the s_axis channel carries an opcode (push, read, write,
// swap, remove_at, top, pop, contains, remove_value), two indices and a
// value; one result item comes out on the m_axis channel for every item
// with the read word, the found flag, the element count, an empty flag
// and a status code
// items are handled one at a time; rejected items and unused opcodes go
// straight to the result; the single read port of the element memory
// paces the shift and the search, which walk the list one slot per cycle
// the input opens in the cycle after the previous result moves into the
// output register, even while the receiver stalls it; its result then waits
// and the input stays closed until the output register frees up
// reset empties the list (count zero) and drops any pending result; the
// element memory itself is not cleared
module array_stack_bag_engine_core #(
  parameter int SLOTS     = 256,
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // opcode[3:0], index_a[11:4], index_b[19:12], value[51:20], zero fill
  input  logic [asbe_pkg::IN_BITS-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_value[31:0], found[32], count[41:33], empty_res[42], status[44:43], zero fill
  output logic [asbe_pkg::OUT_BITS-1:0]   m_axis_tdata
);

  localparam int AW = $clog2(SLOTS);

  logic                        res_valid, res_ready;
  asbe_pkg::res_t              res, out_q;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic signed [WORD_BITS-1:0] mem_wdata, mem_rdata;

  asbe_ctrl #(
    .SLOTS     (SLOTS),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .opcode    (s_axis_tdata[3:0]),
    .index_a   (s_axis_tdata[11:4]),
    .index_b   (s_axis_tdata[19:12]),
    .value     (s_axis_tdata[51:20]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  asbe_mem #(
    .DEPTH (SLOTS),
    .WIDTH (WORD_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {3'b000, out_q};

  // an accepted item keeps the input closed until its result is built
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after accept");

  // a result handed over always shows up on the output
  a_result_loaded : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_axis_tvalid)
    else $error("result lost at output register");

  // errors never report a match or a read word
  a_error_clean : assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != asbe_pkg::ST_OK |-> !res.found && res.read_value == '0)
    else $error("error result carries data");

endmodule
